// ----- rtl/dwpi_pkg.sv -----
// Shared types and constants for the dual-wheel PI speed controller.
package dwpi_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned GainScale = 1000;
  localparam int unsigned FfMul = 3;
  localparam int unsigned FfDivShift = 2;
  localparam int unsigned DriveOffset = 100;

  localparam logic [DataW-1:0] PropGainReset = 16'd1000;
  localparam logic [DataW-1:0] IntGainReset = 16'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTargetRight  = 3'd0,
    CfgTargetLeft   = 3'd1,
    CfgPropGainRight = 3'd2,
    CfgPropGainLeft = 3'd3,
    CfgIntGainRight = 3'd4,
    CfgIntGainLeft  = 3'd5
  } cfg_idx_e;

  // Pipeline control shared by both wheel datapaths.
  typedef struct packed {
    logic accept;
    logic advance;
  } ctrl_t;

endpackage

// ----- rtl/dual_wheel_pi_speed_control.sv -----
// Top level of the dual-wheel PI speed controller: configuration and pipeline control.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   count_right_i, count_left_i
//   out      output     out_valid_o / out_ready_i drive_right_o, drive_left_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One transaction per cycle sustained while the output is not stalled, through a
// seven-register pipeline (integrator, products, magnitude, two divider stages,
// feedforward, output register). The integrators update in the accepting cycle.
// Reset restores the register defaults and clears the integrators and valid bits.
// A stalled output freezes the whole pipeline and drops in_ready_o.
module dual_wheel_pi_speed_control import dwpi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [DataW-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [DataW-1:0]   count_right_i,
  input  logic signed [DataW-1:0]   count_left_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [DataW-1:0]   drive_right_o,
  output logic signed [DataW-1:0]   drive_left_o
);

  localparam int unsigned Depth = 7;

  logic [DataW-1:0] target_r_q, target_l_q;
  logic [DataW-1:0] kp_r_q, kp_l_q, ki_r_q, ki_l_q;
  logic [Depth-1:0] vld_q;
  ctrl_t            ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_r_q <= '0;
      target_l_q <= '0;
      kp_r_q     <= PropGainReset;
      kp_l_q     <= PropGainReset;
      ki_r_q     <= IntGainReset;
      ki_l_q     <= IntGainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTargetRight:   target_r_q <= cfg_data_i;
        CfgTargetLeft:    target_l_q <= cfg_data_i;
        CfgPropGainRight: kp_r_q     <= cfg_data_i;
        CfgPropGainLeft:  kp_l_q     <= cfg_data_i;
        CfgIntGainRight:  ki_r_q     <= cfg_data_i;
        CfgIntGainLeft:   ki_l_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished result is held.
  assign ctrl.advance = !vld_q[Depth-1] || out_ready_i;
  assign ctrl.accept  = in_valid_i && ctrl.advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl.advance) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  dwpi_wheel u_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .target_i (signed'(target_r_q)),
    .kp_i     (kp_r_q),
    .ki_i     (ki_r_q),
    .count_i  (count_right_i),
    .drive_o  (drive_right_o)
  );

  dwpi_wheel u_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .target_i (signed'(target_l_q)),
    .kp_i     (kp_l_q),
    .ki_i     (ki_l_q),
    .count_i  (count_left_i),
    .drive_o  (drive_left_o)
  );

  assign in_ready_o  = ctrl.advance;
  assign out_valid_o = vld_q[Depth-1];

endmodule

// ----- rtl/dwpi_div1000.sv -----
// Two-stage divide-by-1000 of a 48-bit magnitude by reciprocal multiplication.
module dwpi_div1000 import dwpi_pkg::*; (
  input  logic        clk_i,
  input  logic        advance_i,
  input  logic [47:0] mag_i,
  input  logic        neg_i,
  output logic [38:0] quot_o,
  output logic        neg_o
);

  // ceil(2^58 / 1000) is exact for every dividend below 2^48.
  localparam int unsigned Shift = 58;
  localparam logic [63:0] RecipFull =
      ((64'd1 << Shift) + 64'(GainScale) - 64'd1) / 64'(GainScale);
  localparam logic [48:0] Recip = RecipFull[48:0];
  localparam logic [24:0] RecipHi = Recip[48:24];
  localparam logic [23:0] RecipLo = Recip[23:0];

  logic [48:0] p_hh_q, p_lh_q;
  logic [47:0] p_hl_q, p_ll_q;
  logic        neg_a_q;
  logic [96:0] prod_sum;
  logic [38:0] quot_q;
  logic        neg_b_q;

  // Stage A: four partial products.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      p_hh_q  <= 49'(mag_i[47:24]) * 49'(RecipHi);
      p_hl_q  <= 48'(mag_i[47:24]) * 48'(RecipLo);
      p_lh_q  <= 49'(mag_i[23:0]) * 49'(RecipHi);
      p_ll_q  <= 48'(mag_i[23:0]) * 48'(RecipLo);
      neg_a_q <= neg_i;
    end
  end

  assign prod_sum = ({48'd0, p_hh_q} << 48)
                  + ({49'd0, p_hl_q} << 24)
                  + ({48'd0, p_lh_q} << 24)
                  + {49'd0, p_ll_q};

  // Stage B: sum and keep the quotient bits.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      quot_q  <= prod_sum[96:Shift];
      neg_b_q <= neg_a_q;
    end
  end

  assign quot_o = quot_q;
  assign neg_o  = neg_b_q;

endmodule

// ----- rtl/dwpi_wheel.sv -----
// One wheel: error, saturating integrator, PI correction and drive pipeline.
module dwpi_wheel import dwpi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  input  logic signed [DataW-1:0] target_i,
  input  logic        [DataW-1:0] kp_i,
  input  logic        [DataW-1:0] ki_i,
  input  logic signed [DataW-1:0] count_i,
  output logic signed [DataW-1:0] drive_o
);

  logic signed [31:0] integ_q, integ_d;
  logic signed [7:0]  err;
  logic signed [32:0] acc_sum;

  logic signed [7:0]  err_q;
  logic signed [31:0] acc_q;
  logic signed [16:0] kp_s, ki_s;
  logic signed [24:0] pterm_q;
  logic signed [48:0] iterm_q;
  logic signed [49:0] pi_sum;
  logic signed [49:0] pi_mag;
  logic [47:0]        mag_q;
  logic               neg_q;
  logic [38:0]        quot;
  logic               quot_neg;
  logic signed [40:0] corr;
  logic signed [41:0] tsum;
  logic signed [43:0] t3_q;
  logic signed [43:0] t3_adj, t3_quo, drv_wide;
  logic signed [DataW-1:0] drive_q, drive_d;

  // Error keeps only the low byte of target - count.
  assign err     = signed'(target_i[7:0] - count_i[7:0]);
  assign acc_sum = 33'(integ_q) + 33'(err);

  always_comb begin
    integ_d = acc_sum[31:0];
    if (acc_sum[32] != acc_sum[31]) begin
      integ_d = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctrl_i.accept) begin
      integ_q <= integ_d;
    end
  end

  assign kp_s = signed'({1'b0, kp_i});
  assign ki_s = signed'({1'b0, ki_i});

  assign pi_sum = 50'(pterm_q) + 50'(iterm_q);
  assign pi_mag = pi_sum[49] ? -pi_sum : pi_sum;

  dwpi_div1000 u_div (
    .clk_i     (clk_i),
    .advance_i (ctrl_i.advance),
    .mag_i     (mag_q),
    .neg_i     (neg_q),
    .quot_o    (quot),
    .neg_o     (quot_neg)
  );

  always_comb begin
    corr = signed'({2'b00, quot});
    if (quot_neg) begin
      corr = -corr;
    end
  end

  assign tsum = 42'(target_i) + 42'(corr);

  // Divide by four truncating toward zero, then remove the offset.
  assign t3_adj   = t3_q + (t3_q[43] ? 44'sd3 : 44'sd0);
  assign t3_quo   = t3_adj >>> FfDivShift;
  assign drv_wide = t3_quo - 44'(DriveOffset);

  always_comb begin
    drive_d = drv_wide[DataW-1:0];
    if (drv_wide > 44'sd32767) begin
      drive_d = 16'sh7FFF;
    end else if (drv_wide < -44'sd32768) begin
      drive_d = 16'sh8000;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      err_q   <= err;
      acc_q   <= integ_d;
      pterm_q <= 25'(err_q) * 25'(kp_s);
      iterm_q <= 49'(acc_q) * 49'(ki_s);
      mag_q   <= pi_mag[47:0];
      neg_q   <= pi_sum[49];
      t3_q    <= 44'(tsum) * 44'(FfMul);
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

// ----- test/tb_dual_wheel_pi_speed_control.sv -----
// Self-checking testbench for the dual-wheel PI speed controller.
module tb_dual_wheel_pi_speed_control import dwpi_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomTicks = 1950;
  localparam int NumDirected = 25;
  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 12;

  localparam int Right = 0;
  localparam int Left = 1;

  // Arithmetic constants kept signed and wide for the drive prediction.
  localparam longint GainDiv = 1000;
  localparam longint FfNum = 3;
  localparam longint FfDen = 4;
  localparam longint DriveBias = 100;
  localparam longint IntegMax = 64'sd2147483647;
  localparam longint IntegMin = -64'sd2147483648;
  localparam longint DriveMax = 32767;
  localparam longint DriveMin = -32768;

  // Indexes past the last register: writes to them must leave every register alone.
  localparam logic [CfgIdxW-1:0] CfgSpareLow = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = 3'd7;

  typedef enum int {KeepRegs, MaxGains, FfOnly, AllZero, SpareIdx} preset_e;

  typedef struct packed {
    logic signed [DataW-1:0] right;
    logic signed [DataW-1:0] left;
  } drive_pair_t;

  typedef struct {
    preset_e                 preset;
    logic signed [DataW-1:0] cnt_r;
    logic signed [DataW-1:0] cnt_l;
    bit                      known;
    logic signed [DataW-1:0] exp_r;
    logic signed [DataW-1:0] exp_l;
  } tick_row_t;

  // Reset values first, then raw count extremes and byte wrap of the error, then
  // full gains driving both wheels into drive saturation and back, then
  // feedforward alone, all-zero gains and writes to unused indexes.
  tick_row_t directed_rows [NumDirected] = '{
    '{KeepRegs,       0,       0, 1'b1,   -100,   -100},
    '{KeepRegs,   32767,  -32768, 1'b0,      0,      0},
    '{KeepRegs,  -32768,   32767, 1'b0,      0,      0},
    '{KeepRegs,       1,      -1, 1'b0,      0,      0},
    '{KeepRegs,     127,    -128, 1'b0,      0,      0},
    '{KeepRegs,    -129,     128, 1'b0,      0,      0},
    '{KeepRegs,   21845,  -21846, 1'b0,      0,      0},
    '{MaxGains,    -127,     128, 1'b0,      0,      0},
    '{KeepRegs,    -127,     128, 1'b0,      0,      0},
    '{KeepRegs,    -127,     128, 1'b0,      0,      0},
    '{KeepRegs,    -127,     128, 1'b0,      0,      0},
    '{KeepRegs,    -127,     128, 1'b0,      0,      0},
    '{KeepRegs,    -127,     128, 1'b0,      0,      0},
    '{KeepRegs,     128,    -127, 1'b0,      0,      0},
    '{KeepRegs,     128,    -127, 1'b0,      0,      0},
    '{KeepRegs,     128,    -127, 1'b0,      0,      0},
    '{KeepRegs,     128,    -127, 1'b0,      0,      0},
    '{KeepRegs,     128,    -127, 1'b0,      0,      0},
    '{KeepRegs,     128,    -127, 1'b0,      0,      0},
    '{KeepRegs,     128,    -127, 1'b0,      0,      0},
    '{KeepRegs,     128,    -127, 1'b0,      0,      0},
    '{KeepRegs,     128,    -127, 1'b0,      0,      0},
    '{FfOnly,      1234,   -4321, 1'b1,  24475, -24676},
    '{AllZero,     -500,     500, 1'b1,   -100,   -100},
    '{SpareIdx,     777,    -777, 1'b1,   -100,   -100}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = '0;
  logic [DataW-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [DataW-1:0] count_right_i = '0;
  logic signed [DataW-1:0] count_left_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] drive_right_o;
  logic signed [DataW-1:0] drive_left_o;

  // Register and integrator mirror, index Right or Left.
  logic signed [DataW-1:0] target_q [2];
  logic [DataW-1:0]        prop_gain_q [2];
  logic [DataW-1:0]        int_gain_q [2];
  logic signed [31:0]      integ_q [2];

  drive_pair_t             pending_drives [$];
  bit                      row_known = 1'b0;
  drive_pair_t             row_drives = '0;
  bit                      calm = 1'b0;
  int                      ready_hold = 0;
  int                      cycle_count = 0;
  int                      mismatch_count = 0;
  int                      ticks_accepted = 0;
  int                      drives_checked = 0;
  int                      reg_writes = 0;

  dual_wheel_pi_speed_control u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .count_right_i (count_right_i),
    .count_left_i  (count_left_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_right_o (drive_right_o),
    .drive_left_o  (drive_left_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // One wheel of one control tick: advance the integrator, return the drive.
  function automatic logic signed [DataW-1:0] predict_drive(int w,
                                                            logic signed [DataW-1:0] cnt);
    logic [DataW-1:0] diff;
    longint           err;
    longint           acc;
    longint           corr;
    longint           drv;
    diff = target_q[w] - cnt;
    err = longint'($signed(diff[7:0]));
    acc = longint'(integ_q[w]) + err;
    if (acc > IntegMax) acc = IntegMax;
    if (acc < IntegMin) acc = IntegMin;
    integ_q[w] = acc[31:0];
    corr = (err * longint'(prop_gain_q[w]) + acc * longint'(int_gain_q[w])) / GainDiv;
    drv = (FfNum * (longint'(target_q[w]) + corr)) / FfDen - DriveBias;
    if (drv > DriveMax) drv = DriveMax;
    if (drv < DriveMin) drv = DriveMin;
    return drv[DataW-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DataW-1:0] rand_target();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  // Called at a falling edge; leaves the write enable high for the caller to drop.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      CfgTargetRight:   target_q[Right] = data;
      CfgTargetLeft:    target_q[Left] = data;
      CfgPropGainRight: prop_gain_q[Right] = data;
      CfgPropGainLeft:  prop_gain_q[Left] = data;
      CfgIntGainRight:  int_gain_q[Right] = data;
      CfgIntGainLeft:   int_gain_q[Left] = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic apply_preset(preset_e p);
    case (p)
      MaxGains: begin
        write_reg(CfgTargetRight, 16'h0000);
        write_reg(CfgTargetLeft, 16'h0000);
        write_reg(CfgPropGainRight, 16'hffff);
        write_reg(CfgPropGainLeft, 16'hffff);
        write_reg(CfgIntGainRight, 16'hffff);
        write_reg(CfgIntGainLeft, 16'hffff);
      end
      FfOnly: begin
        write_reg(CfgTargetRight, 16'h7fff);
        write_reg(CfgTargetLeft, 16'h8000);
        write_reg(CfgPropGainRight, 16'h0000);
        write_reg(CfgPropGainLeft, 16'h0000);
        write_reg(CfgIntGainRight, 16'h0000);
        write_reg(CfgIntGainLeft, 16'h0000);
      end
      AllZero: begin
        write_reg(CfgTargetRight, 16'h0000);
        write_reg(CfgTargetLeft, 16'h0000);
      end
      SpareIdx: begin
        write_reg(CfgSpareLow, 16'hffff);
        write_reg(CfgSpareHigh, 16'hffff);
      end
      default: ;
    endcase
    cfg_we_i = 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_tick(logic signed [DataW-1:0] cr, logic signed [DataW-1:0] cl,
                           bit known, drive_pair_t typed);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    count_right_i = cr;
    count_left_i = cl;
    row_known = known;
    row_drives = typed;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_drives.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      out_ready_i = 1'b0;
      ready_hold--;
    end else begin
      out_ready_i = 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) ready_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_drives.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check the output transaction first, then record the input one of the same edge.
  always @(posedge clk_i) begin : check_drives
    drive_pair_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_drives.size() == 0) begin
          $error("unexpected drive transaction: right %0d left %0d", drive_right_o,
                 drive_left_o);
          mismatch_count++;
        end else begin
          want = pending_drives.pop_front();
          drives_checked++;
          if (drive_right_o !== want.right) begin
            $error("drive_right: expected %0d, got %0d", want.right, drive_right_o);
            mismatch_count++;
          end
          if (drive_left_o !== want.left) begin
            $error("drive_left: expected %0d, got %0d", want.left, drive_left_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want.right = predict_drive(Right, count_right_i);
        want.left = predict_drive(Left, count_left_i);
        if (row_known) want = row_drives;
        pending_drives.push_back(want);
        ticks_accepted++;
      end
    end
  end

  initial begin : stimulus
    int          sent;
    int          n;
    logic [15:0] delta_r;
    logic [15:0] delta_l;
    logic signed [DataW-1:0] cr;
    logic signed [DataW-1:0] cl;
    target_q[Right] = '0;
    target_q[Left] = '0;
    prop_gain_q[Right] = PropGainReset;
    prop_gain_q[Left] = PropGainReset;
    int_gain_q[Right] = IntGainReset;
    int_gain_q[Left] = IntGainReset;
    integ_q[Right] = '0;
    integ_q[Left] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].preset != KeepRegs) begin
        drain();
        apply_preset(directed_rows[i].preset);
      end
      send_tick(directed_rows[i].cnt_r, directed_rows[i].cnt_l, directed_rows[i].known,
                '{directed_rows[i].exp_r, directed_rows[i].exp_l});
    end

    sent = 0;
    while (sent < RandomTicks) begin
      drain();
      calm = 1'b1;
      if ($urandom_range(0, 1)) write_reg(CfgTargetRight, rand_target());
      if ($urandom_range(0, 1)) write_reg(CfgTargetLeft, rand_target());
      if ($urandom_range(0, 1)) write_reg(CfgPropGainRight, rand_gain());
      if ($urandom_range(0, 1)) write_reg(CfgPropGainLeft, rand_gain());
      if ($urandom_range(0, 1)) write_reg(CfgIntGainRight, rand_gain());
      if ($urandom_range(0, 1)) write_reg(CfgIntGainLeft, rand_gain());
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? CfgSpareHigh : CfgSpareLow,
                  16'($urandom_range(0, 65535)));
      cfg_we_i = 1'b0;
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 120);
      repeat (n) begin
        // Mostly counts near the target, wrapping the error byte now and then.
        delta_r = 16'($urandom_range(0, 260) - 130);
        delta_l = 16'($urandom_range(0, 260) - 130);
        cr = target_q[Right] - delta_r;
        cl = target_q[Left] - delta_l;
        if ($urandom_range(0, 4) == 0) cr = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 4) == 0) cl = 16'($urandom_range(0, 65535));
        send_tick(cr, cl, 1'b0, '0);
        sent++;
      end
    end

    drain();
    calm = 1'b1;
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_drives.size() != 0) begin
      $error("%0d expected drives never arrived", pending_drives.size());
      mismatch_count++;
    end
    $display("Ran %0d control ticks (%0d directed) through %0d register writes,",
             ticks_accepted, NumDirected, reg_writes);
    $display("compared %0d drive pairs, %0d field mismatches.", drives_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
